// File: hdl/flow_tracking_table_with_aging_unit_defines.svh
// Assertion macros for the flow table block.
`ifndef FLOW_TRACKING_TABLE_WITH_AGING_UNIT_DEFINES_SVH
`define FLOW_TRACKING_TABLE_WITH_AGING_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define FT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define FT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define FT_ASSERT(label, clk, rst_n, prop, msg)
`define FT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: hdl/ftt_pkg.sv
// Shared types and constants for the flow table block.
package ftt_pkg;
  localparam int unsigned FlowEntries = 1024;
  localparam int unsigned SlotW = $clog2(FlowEntries);
  localparam int unsigned CntW = $clog2(FlowEntries + 1);

  localparam logic [1:0] KindTouch = 2'd0;
  localparam logic [1:0] KindTick  = 2'd1;
  localparam logic [1:0] KindSweep = 2'd2;

  localparam logic [2:0] StUpdated = 3'd0;
  localparam logic [2:0] StAdded   = 3'd1;
  localparam logic [2:0] StFull    = 3'd2;
  localparam logic [2:0] StTick    = 3'd3;
  localparam logic [2:0] StSweep   = 3'd4;

  localparam logic RegTimeout = 1'b0;
  localparam logic RegMaxRem  = 1'b1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] iface_index;
    logic        is_v6;
    logic [63:0] src_addr_hi;
    logic [63:0] src_addr_lo;
    logic [63:0] dst_addr_hi;
    logic [63:0] dst_addr_lo;
    logic [7:0]  proto;
    logic [15:0] src_port_num;
    logic [15:0] dst_port_num;
    logic [63:0] subscriber;
    logic [15:0] packet_bytes;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  flow_slot;
    logic [63:0] flow_packet_count;
    logic [63:0] flow_byte_count;
    logic [10:0] removed_count;
  } out_item_t;

  typedef struct packed {
    logic [31:0] iface;
    logic [8:0]  pv;
    logic [31:0] ports;
    logic [63:0] src_hi;
    logic [63:0] src_lo;
    logic [63:0] dst_hi;
    logic [63:0] dst_lo;
  } key_t;

  typedef struct packed {
    logic        valid;
    key_t        key;
    logic [63:0] sub;
    logic [31:0] last_seen;
    logic [63:0] pkts;
    logic [63:0] bytes;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [SlotW-1:0] waddr;
    entry_t           wdata;
    logic [SlotW-1:0] raddr;
  } mem_req_t;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_SCAN, S_CHECK, S_WRITE, S_OUT
  } state_e;
endpackage

// File: hdl/ftt_entry_ram.sv
// Entry store: one synchronous RAM with a registered read.
module ftt_entry_ram import ftt_pkg::*; (
  input  logic     clk_i,
  input  mem_req_t req_i,
  output entry_t   rdata_o
);
  entry_t mem [FlowEntries];
  always_ff @(posedge clk_i) begin
    if (req_i.we) mem[req_i.waddr] <= req_i.wdata;
    rdata_o <= mem[req_i.raddr];
  end
endmodule

// File: hdl/flow_tracking_table_with_aging_unit.sv
// Top level of the flow table with idle-timeout aging.
// Every flow entry, its valid bit included, lives in one entry RAM (one read
// and one write port, registered read data); after reset a clearing pass
// zeroes all FlowEntries (1024) slots while the input stalls. Touches and
// sweeps walk the table one slot per cycle. A tick gives its result without
// a walk; a touch stops at the matching slot, or walks the whole table when
// it misses (added or table full); a sweep walks the whole table or stops
// once the removal limit is reached. An unused kind is dropped with no
// result. One item is in flight at a time: the input stalls until its result
// is registered and takes the next item in the same cycle in which that result
// appears; a finished result waits as long as an older result is held by a
// stall.
`include "flow_tracking_table_with_aging_unit_defines.svh"
module flow_tracking_table_with_aging_unit import ftt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [30:0] cfg_data_i
);
  state_e state_q, state_d;
  in_item_t item_q;
  logic [31:0] time_q;
  logic [30:0] timeout_q;
  logic [10:0] maxrem_q;
  logic [SlotW:0] idx_q, idx_d;       // scan address, wide enough for the end
  logic [SlotW-1:0] chk_q;            // slot whose data is on the RAM output
  logic have_free_q, hit_q;
  logic [SlotW-1:0] free_q;
  logic [CntW-1:0] removed_q;
  logic [63:0] pkts_q, bytes_q;
  out_item_t res_q, res_d;
  logic res_valid_q, res_valid_d;
  mem_req_t req;
  entry_t rdata;
  key_t in_key;
  logic accept, match, idle, limit_hit, drop, retire;
  logic [10:0] limit;

  ftt_entry_ram u_ram (.clk_i, .req_i(req), .rdata_o(rdata));

  assign in_key = '{iface: item_q.iface_index, pv: {item_q.is_v6, item_q.proto},
                    ports: {item_q.src_port_num, item_q.dst_port_num},
                    src_hi: item_q.src_addr_hi, src_lo: item_q.src_addr_lo,
                    dst_hi: item_q.dst_addr_hi, dst_lo: item_q.dst_addr_lo};
  assign in_stall_o = (state_q != S_IDLE);
  assign accept = in_valid_i && !in_stall_o;
  assign out_valid_o = res_valid_q;
  assign out_data_o = res_q;
  assign limit = (maxrem_q == '0) ? 11'd1 : maxrem_q;
  assign limit_hit = (11'(removed_q) >= limit);
  assign match = rdata.valid && (rdata.key == in_key);
  assign idle = (32'(time_q - rdata.last_seen) >= {1'b0, timeout_q});
  assign drop = (state_q == S_CHECK) && (item_q.kind == KindSweep) && !limit_hit &&
                rdata.valid && idle;
  // hand over only once the older beat has left
  assign retire = (state_q == S_OUT) && (!res_valid_q || !out_stall_i);
  assign res_valid_d = retire || (res_valid_q && out_stall_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (idx_q[SlotW-1:0] == SlotW'(FlowEntries - 1)) state_d = S_IDLE;
      S_IDLE: if (accept) begin
        priority if (in_data_i.kind == KindTouch || in_data_i.kind == KindSweep)
          state_d = S_SCAN;
        else if (in_data_i.kind == KindTick) state_d = S_OUT;
        else state_d = S_IDLE;
      end
      S_SCAN:  state_d = S_CHECK;
      S_CHECK: begin
        if (item_q.kind == KindTouch) begin
          if (match || idx_q[SlotW]) state_d = S_WRITE;
        end else if (limit_hit || idx_q[SlotW]) begin
          state_d = S_OUT;
        end
      end
      S_WRITE: state_d = S_OUT;
      S_OUT:   if (retire) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    req = '0;
    idx_d = idx_q;
    req.raddr = idx_q[SlotW-1:0];
    if (accept) idx_d = '0;
    else if (state_q == S_CLEAR || state_q == S_SCAN || state_q == S_CHECK)
      idx_d = idx_q + 1'b1;
    if (state_q == S_CLEAR) begin
      req.we = 1'b1;
      req.waddr = idx_q[SlotW-1:0];
    end
    if (drop) begin
      req.we = 1'b1;
      req.waddr = chk_q;
      req.wdata = rdata;
      req.wdata.valid = 1'b0;
    end
    if (state_q == S_WRITE) begin
      req.waddr = hit_q ? chk_q : free_q;
      req.we = hit_q || have_free_q;
      req.wdata.valid = 1'b1;
      req.wdata.key = in_key;
      req.wdata.sub = item_q.subscriber;
      req.wdata.last_seen = time_q;
      req.wdata.pkts = hit_q ? pkts_q : 64'd1;
      req.wdata.bytes = hit_q ? bytes_q : 64'(item_q.packet_bytes);
    end
  end

  always_comb begin
    res_d = '0;
    priority if (item_q.kind == KindTick) begin
      res_d.status = StTick;
    end else if (item_q.kind == KindSweep) begin
      res_d.status = StSweep;
      res_d.removed_count = 11'(removed_q);
    end else if (hit_q) begin
      res_d.status = StUpdated;
      res_d.flow_slot = 10'(chk_q);
      res_d.flow_packet_count = pkts_q;
      res_d.flow_byte_count = bytes_q;
    end else if (have_free_q) begin
      res_d.status = StAdded;
      res_d.flow_slot = 10'(free_q);
      res_d.flow_packet_count = 64'd1;
      res_d.flow_byte_count = 64'(item_q.packet_bytes);
    end else begin
      res_d.status = StFull;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      item_q <= '0;
      time_q <= '0;
      timeout_q <= 31'd60;
      maxrem_q <= 11'd1024;
      idx_q <= '0;
      chk_q <= '0;
      res_q <= '0;
      res_valid_q <= 1'b0;
      have_free_q <= 1'b0;
      hit_q <= 1'b0;
      free_q <= '0;
      removed_q <= '0;
      pkts_q <= '0;
      bytes_q <= '0;
    end else begin
      state_q <= state_d;
      idx_q <= idx_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        if (cfg_index_i == RegTimeout) timeout_q <= cfg_data_i;
        else maxrem_q <= cfg_data_i[10:0];
      end
      if (accept) begin
        item_q <= in_data_i;
        have_free_q <= 1'b0;
        hit_q <= 1'b0;
        removed_q <= '0;
      end
      // hold the matched slot once the walk stops
      if (state_d == S_CHECK) chk_q <= idx_q[SlotW-1:0];
      if (state_q == S_CHECK && item_q.kind == KindTouch) begin
        if (match) begin
          hit_q <= 1'b1;
          pkts_q <= rdata.pkts + 64'd1;
          bytes_q <= rdata.bytes + 64'(item_q.packet_bytes);
        end
        if (!rdata.valid && !have_free_q) begin
          have_free_q <= 1'b1;
          free_q <= chk_q;
        end
      end
      if (drop) removed_q <= removed_q + 1'b1;
      if (retire) begin
        res_q <= res_d;
        if (item_q.kind == KindTick) time_q <= time_q + 32'd1;
      end
    end
  end

  `FT_ASSERT(a_busy_stall, clk_i, rst_ni, (state_q == S_IDLE) || in_stall_o, "busy not stalled")
  `FT_ASSERT(a_rem_lim, clk_i, rst_ni, 11'(removed_q) <= 11'd1024, "removals overflow")
  `FT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "result dropped")
endmodule

// File: bench/tb_flow_tracking_table_with_aging_unit.sv
// Self-checking bench for the flow table with idle-timeout aging.
`timescale 1ns / 1ps
module tb_flow_tracking_table_with_aging_unit import ftt_pkg::*; ();

  localparam logic [1:0] KindUnused = 2'd3;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned StallLimit = 20000;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic      clk, rst_n;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_we = 1'b0;
  logic      cfg_index = RegTimeout;
  logic [30:0] cfg_data = '0;

  // mirror of the flow table
  bit          slot_used [FlowEntries];
  key_t        slot_key  [FlowEntries];
  logic [63:0] slot_sub  [FlowEntries];
  logic [31:0] slot_seen [FlowEntries];
  logic [63:0] slot_pkts [FlowEntries];
  logic [63:0] slot_bytes[FlowEntries];
  logic [31:0] now_tick = '0;
  logic [30:0] timeout_ticks = 31'd60;
  logic [10:0] removal_cap = 11'd1024;

  out_item_t pending_results[$];
  in_item_t  flow_pool[16];
  dir_row_t  dir_rows[$];
  int tx_idle_pct = 0, rx_stall_pct = 0;
  int errors = 0, items_sent = 0, results_seen = 0, quiet_cycles = 0;
  int n_full = 0, n_removed = 0;

  flow_tracking_table_with_aging_unit i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic key_t key_of(in_item_t it);
    key_t k;
    k.iface  = it.iface_index;
    k.pv     = {it.is_v6, it.proto};
    k.ports  = {it.src_port_num, it.dst_port_num};
    k.src_hi = it.src_addr_hi;
    k.src_lo = it.src_addr_lo;
    k.dst_hi = it.dst_addr_hi;
    k.dst_lo = it.dst_addr_lo;
    return k;
  endfunction

  function automatic out_item_t flow_predict(in_item_t it, output bit has_res);
    out_item_t r;
    key_t k;
    int free_slot;
    int removed;
    r = '0;
    has_res = 1'b1;
    free_slot = -1;
    removed = 0;
    case (it.kind)
      KindTouch: begin
        k = key_of(it);
        for (int i = 0; i < FlowEntries; i++) begin
          if (!slot_used[i]) begin
            if (free_slot < 0) free_slot = i;
          end else if (slot_key[i] == k) begin
            slot_seen[i] = now_tick;
            slot_sub[i] = it.subscriber;
            slot_pkts[i] += 64'd1;
            slot_bytes[i] += {48'd0, it.packet_bytes};
            r.status = StUpdated;
            r.flow_slot = i[9:0];
            r.flow_packet_count = slot_pkts[i];
            r.flow_byte_count = slot_bytes[i];
            return r;
          end
        end
        if (free_slot < 0) begin
          r.status = StFull;
          n_full++;
          return r;
        end
        slot_used[free_slot] = 1'b1;
        slot_key[free_slot] = k;
        slot_sub[free_slot] = it.subscriber;
        slot_seen[free_slot] = now_tick;
        slot_pkts[free_slot] = 64'd1;
        slot_bytes[free_slot] = {48'd0, it.packet_bytes};
        r.status = StAdded;
        r.flow_slot = free_slot[9:0];
        r.flow_packet_count = 64'd1;
        r.flow_byte_count = {48'd0, it.packet_bytes};
      end
      KindTick: begin
        now_tick += 32'd1;
        r.status = StTick;
      end
      KindSweep: begin
        // a cap of zero still lets one flow go
        for (int i = 0; i < FlowEntries && removed < ((removal_cap == 0) ? 1 : removal_cap);
             i++) begin
          if (slot_used[i] && (now_tick - slot_seen[i]) >= {1'b0, timeout_ticks}) begin
            slot_used[i] = 1'b0;
            removed++;
          end
        end
        r.status = StSweep;
        r.removed_count = removed[10:0];
        n_removed += removed;
      end
      default: has_res = 1'b0;
    endcase
    return r;
  endfunction

  function automatic in_item_t mk_touch(logic [31:0] ifc, logic v6, logic [63:0] addr,
                                        logic [7:0] pr, logic [15:0] sp, logic [15:0] dp,
                                        logic [63:0] sub, logic [15:0] nbytes);
    in_item_t it;
    it.kind = KindTouch;
    it.iface_index = ifc;
    it.is_v6 = v6;
    it.src_addr_hi = addr;
    it.src_addr_lo = addr;
    it.dst_addr_hi = addr;
    it.dst_addr_lo = addr;
    it.proto = pr;
    it.src_port_num = sp;
    it.dst_port_num = dp;
    it.subscriber = sub;
    it.packet_bytes = nbytes;
    return it;
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    logic [575:0] noise;
    int pick;
    noise = {rand64(), rand64(), rand64(), rand64(), rand64(), rand64(), rand64(),
             rand64(), rand64()};
    it = noise[$bits(in_item_t)-1:0];
    pick = $urandom_range(99);
    if (pick < 5) it.kind = KindUnused;
    else if (pick < 18) it.kind = KindSweep;
    else if (pick < 45) it.kind = KindTick;
    else begin
      if ($urandom_range(4) != 0) begin
        it = flow_pool[$urandom_range(15)];
        it.subscriber = rand64();
        it.packet_bytes = 16'($urandom);
      end
      it.kind = KindTouch;
    end
    return it;
  endfunction

  function automatic void refresh_pool();
    for (int i = 0; i < 16; i++) begin
      flow_pool[i] = mk_touch($urandom, 1'b1, rand64(), 8'($urandom), 16'($urandom),
                              16'($urandom), 64'd0, 16'd0);
      flow_pool[i].src_addr_lo = rand64();
      flow_pool[i].dst_addr_hi = rand64();
      flow_pool[i].dst_addr_lo = rand64();
      if (i[0]) begin
        // IPv4 shape: upper words zero, address in the low 32 bits
        flow_pool[i].is_v6 = 1'b0;
        flow_pool[i].src_addr_hi = '0;
        flow_pool[i].dst_addr_hi = '0;
        flow_pool[i].src_addr_lo[63:32] = '0;
        flow_pool[i].dst_addr_lo[63:32] = '0;
      end
    end
  endfunction

  task automatic drive_item(input in_item_t it, input bit typed, input out_item_t want);
    out_item_t pred;
    bit has_res;
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = flow_predict(it, has_res);
    if (has_res) pending_results.push_back(typed ? want : pred);
    items_sent++;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
    // then stay idle before touching the registers
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [30:0] val);
    in_valid <= 1'b0;
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == RegTimeout) timeout_ticks = val;
    else removal_cap = val[10:0];
  endtask

  task automatic run_phase(input logic [30:0] tmo, input logic [30:0] cap,
                           input int tx_pct, input int rx_pct, input int count);
    write_reg(RegTimeout, tmo);
    write_reg(RegMaxRem, cap);
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    refresh_pool();
    for (int n = 0; n < count; n++) drive_item(rand_item(), 1'b0, '0);
  endtask

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  // compare each result beat against the oldest prediction
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t unexpected result %p", $realtime, out_data);
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status ||
            out_data.flow_slot !== want.flow_slot ||
            out_data.flow_packet_count !== want.flow_packet_count ||
            out_data.flow_byte_count !== want.flow_byte_count ||
            out_data.removed_count !== want.removed_count) begin
          errors++;
          $display("%0t mismatch expected %p actual %p", $realtime, want, out_data);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > StallLimit) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    in_item_t ones;
    in_item_t ipv4;
    for (int i = 0; i < FlowEntries; i++) slot_used[i] = 1'b0;
    ones = mk_touch('1, 1'b1, '1, '1, '1, '1, '0, 16'd0);
    ipv4 = mk_touch(32'd7, 1'b0, 64'h0, 8'd6, 16'd80, 16'd443, 64'h1234, 16'd60);
    ipv4.src_addr_lo = 64'hC0A8_0001;
    ipv4.dst_addr_lo = 64'h0A00_0002;
    dir_rows.push_back('{mk_touch('0, 1'b0, '0, '0, '0, '0, '0, 16'hFFFF), 1'b1,
                         '{StAdded, 10'd0, 64'd1, 64'hFFFF, 11'd0}});
    dir_rows.push_back('{mk_touch('0, 1'b0, '0, '0, '0, '0, '1, 16'hFFFF), 1'b1,
                         '{StUpdated, 10'd0, 64'd2, 64'h1FFFE, 11'd0}});
    dir_rows.push_back('{ones, 1'b1, '{StAdded, 10'd1, 64'd1, 64'd0, 11'd0}});
    ones.is_v6 = 1'b0;
    dir_rows.push_back('{ones, 1'b1, '{StAdded, 10'd2, 64'd1, 64'd0, 11'd0}});
    ones.kind = KindTick;
    dir_rows.push_back('{ones, 1'b1, '{StTick, 10'd0, 64'd0, 64'd0, 11'd0}});
    ones.kind = KindUnused;
    dir_rows.push_back('{ones, 1'b0, '0});
    ones.kind = KindSweep;
    dir_rows.push_back('{ones, 1'b1, '{StSweep, 10'd0, 64'd0, 64'd0, 11'd0}});
    dir_rows.push_back('{mk_touch('0, 1'b0, '0, '0, '0, '0, '0, 16'd1), 1'b1,
                         '{StUpdated, 10'd0, 64'd3, 64'h1FFFF, 11'd0}});
    dir_rows.push_back('{ipv4, 1'b0, '0});
    ipv4.src_port_num = 16'd443;
    ipv4.dst_port_num = 16'd80;
    dir_rows.push_back('{ipv4, 1'b0, '0});
    dir_rows.push_back('{ipv4, 1'b0, '0});
    dir_rows.push_back('{mk_touch(32'd7, 1'b1, 64'h0, 8'd6, 16'd443, 16'd80, '0, 16'd9), 1'b0,
                         '0});

    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[r]) drive_item(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].want);

    // fill the table to the last slot, then overflow it
    for (int i = 0; i < FlowEntries - 4; i++) begin
      drive_item(mk_touch(32'hF000_0000 + i, 1'b0, 64'd5, 8'd17, i[15:0], 16'd53,
                          rand64(), 16'($urandom)), 1'b0, '0);
    end
    write_reg(RegTimeout, 31'd0);
    write_reg(RegMaxRem, 31'd0);
    drive_item(mk_touch('1, 1'b1, '1, '1, '1, '1, '0, 16'd3), 1'b0, '0);
    drive_item(rand_item(), 1'b0, '0);
    ones.kind = KindSweep;
    drive_item(ones, 1'b0, '0);
    write_reg(RegMaxRem, 31'd1024);
    drive_item(ones, 1'b0, '0);

    run_phase(31'd60, 31'd1024, 0, 0, 12);
    run_phase(31'd1, 31'd1, 66, 0, 12);
    run_phase(31'h7FFF_FFFF, 31'd2047, 0, 66, 12);
    run_phase(31'd0, 31'd0, 18, 18, 12);
    run_phase(31'd5, 31'd3, 66, 66, 12);
    in_valid <= 1'b0;
    wait_drained();

    $display("sent %0d items, checked %0d results: directed rows, a full table fill",
             items_sent, results_seen);
    $display("and five random idling phases; table-full drops %0d, flows aged out %0d, ticks %0d",
             n_full, n_removed, now_tick);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

// File: sim.f
+incdir+hdl
hdl/ftt_pkg.sv
hdl/ftt_entry_ram.sv
hdl/flow_tracking_table_with_aging_unit.sv
bench/tb_flow_tracking_table_with_aging_unit.sv
